[rtl/core/psl_pkg.sv]
// Shared constants and types for the prime sieve lister.
package psl_pkg;

    // Largest limit that is sieved; a larger limit is reported out of range.
    localparam int MAX_N  = 256;
    // Width of the incoming limit and of a listed prime.
    localparam int LIM_W  = 10;
    localparam int VAL_W  = 9;
    // Bitmap index width and width of a count that can hold MAX_N itself.
    localparam int ADDR_W = $clog2(MAX_N);
    localparam int CNT_W  = $clog2(MAX_N + 1);

    // Command classes decided by the front part.
    localparam logic [1:0] CMD_SIEVE = 2'd0;
    localparam logic [1:0] CMD_EMPTY = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    // Result status codes.
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] n;
    } t_cmd;

endpackage

[rtl/core/prime_sieve_lister_unit.sv]
// Top level of the prime sieve lister: front classifier, command queue and sieve engine.
//
// Each transfer carries a limit n, and the block lists every prime below n in ascending order,
// flagging the last one; a limit of two or less yields one empty result marked last, and a limit
// above MAX_N yields one result with the out-of-range status. A command in range first loads
// the candidate bitmap, entries zero to n-1. Striking then writes each multiple, stepping by i
// from i*i for every i whose square is below n, prime or not (481 strikes at n = 256); after the
// multiples of one i it steps on to the next square, and a final step leaves for the scan. The
// scan reads and then checks each entry from two to n-1. The single bitmap RAM is written while
// loading and striking and read while scanning, and a stall on the result side holds the scan
// while a found prime waits. Up to two further commands are queued while one is being worked,
// and results wait in an output register.
module prime_sieve_lister_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [psl_pkg::LIM_W-1:0]  i_limit_n,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [psl_pkg::VAL_W-1:0]  o_prime_value,
    output logic                       o_has_prime,
    output logic                       o_last_result,
    output logic                       o_status
);
    import psl_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    // Accept and classify limits.
    psl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_limit_n   (i_limit_n),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Sieve and list.
    psl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_prime_value (o_prime_value),
        .o_has_prime   (o_has_prime),
        .o_last_result (o_last_result),
        .o_status      (o_status)
    );

endmodule

[rtl/core/psl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module psl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/psl_front.sv]
// Front part: accepts limits, classifies them and queues the commands.
module psl_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [psl_pkg::LIM_W-1:0]  i_limit_n,
    output logic                       o_cmd_valid,
    output psl_pkg::t_cmd              o_cmd,
    input  logic                       i_cmd_pop
);
    import psl_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    t_cmd       w_cmd;

    // Classify the incoming limit.
    always_comb begin
        w_cmd.n = CNT_W'(i_limit_n);
        if (i_limit_n > LIM_W'(MAX_N)) begin
            w_cmd.kind = CMD_RANGE;
        end else if (i_limit_n <= LIM_W'(2)) begin
            w_cmd.kind = CMD_EMPTY;
        end else begin
            w_cmd.kind = CMD_SIEVE;
        end
    end

    assign o_stall     = (r_count == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue payload; needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("command queue overfilled");

    // A pop is only ever taken from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != 2'd0)) else $error("pop from empty queue");

    // A transfer into a full queue is refused.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) && !i_cmd_pop |=> (r_count == 2'd2))
        else $error("queue lost its fill");

endmodule

[rtl/core/psl_back.sv]
// Back part: runs the sieve over the bitmap RAM and lists the primes.
module psl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  psl_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [psl_pkg::VAL_W-1:0]  o_prime_value,
    output logic                       o_has_prime,
    output logic                       o_last_result,
    output logic                       o_status
);
    import psl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W:0]   r_sq, n_sq;
    logic [CNT_W:0]   r_m, n_m;
    logic             r_status, n_status;
    logic             r_have_pend, n_have_pend;
    logic [VAL_W-1:0] r_pend, n_pend;

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic             r_out_has, n_out_has;
    logic             r_out_last, n_out_last;
    logic             r_out_status, n_out_status;

    logic              w_slot_free;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_wdata;
    logic              w_re;
    logic              w_rdata;
    logic [CNT_W:0]    w_step;

    psl_ram #(
        .WIDTH (1),
        .DEPTH (MAX_N)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_out_valid || !i_stall;
    // Distance from one square to the next: 2i + 1.
    assign w_step      = {r_i, 1'b1};

    // Sequencer: load candidates, strike multiples, then scan and list.
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_addr       = r_addr;
        n_i          = r_i;
        n_sq         = r_sq;
        n_m          = r_m;
        n_status     = r_status;
        n_have_pend  = r_have_pend;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_has    = r_out_has;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_cmd_pop    = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_addr[ADDR_W-1:0];
        w_wdata      = 1'b0;
        w_re         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_n         = i_cmd.n;
                    n_addr      = '0;
                    n_have_pend = 1'b0;
                    n_status    = (i_cmd.kind == CMD_RANGE) ? ST_RANGE : ST_OK;
                    n_state     = (i_cmd.kind == CMD_SIEVE) ? S_INIT : S_FIN;
                end
            end
            S_INIT: begin
                // Entries below two are not candidates.
                w_we    = 1'b1;
                w_wdata = (r_addr >= CNT_W'(2));
                if (r_addr == r_n - CNT_W'(1)) begin
                    n_state = S_MARK;
                    n_i     = CNT_W'(2);
                    n_sq    = (CNT_W+1)'(4);
                    n_m     = (CNT_W+1)'(4);
                end else begin
                    n_addr = r_addr + CNT_W'(1);
                end
            end
            S_MARK: begin
                // Strike i*i, i*i+i, ... below n for each i with i*i below n.
                if (r_sq >= {1'b0, r_n}) begin
                    n_state = S_RD;
                    n_addr  = CNT_W'(2);
                end else if (r_m < {1'b0, r_n}) begin
                    w_we    = 1'b1;
                    w_waddr = r_m[ADDR_W-1:0];
                    w_wdata = 1'b0;
                    n_m     = r_m + {1'b0, r_i};
                end else begin
                    n_i  = r_i + CNT_W'(1);
                    n_sq = r_sq + w_step;
                    n_m  = r_sq + w_step;
                end
            end
            S_RD: begin
                if (r_addr == r_n) begin
                    n_state = S_FIN;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // A prime is held back until the next one shows it is not the last.
                if (w_rdata && r_have_pend) begin
                    if (w_slot_free) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = r_pend;
                        n_out_has    = 1'b1;
                        n_out_last   = 1'b0;
                        n_out_status = ST_OK;
                        n_pend       = VAL_W'(r_addr);
                        n_addr       = r_addr + CNT_W'(1);
                        n_state      = S_RD;
                    end
                end else begin
                    if (w_rdata) begin
                        n_pend      = VAL_W'(r_addr);
                        n_have_pend = 1'b1;
                    end
                    n_addr  = r_addr + CNT_W'(1);
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_have_pend ? r_pend : '0;
                    n_out_has    = r_have_pend;
                    n_out_last   = 1'b1;
                    n_out_status = r_status;
                    n_have_pend  = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_addr       <= n_addr;
        r_i          <= n_i;
        r_sq         <= n_sq;
        r_m          <= n_m;
        r_status     <= n_status;
        r_pend       <= n_pend;
        r_out_value  <= n_out_value;
        r_out_has    <= n_out_has;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_valid       = r_out_valid;
    assign o_prime_value = r_out_value;
    assign o_has_prime   = r_out_has;
    assign o_last_result = r_out_last;
    assign o_status      = r_out_status;

    // Striking never writes at or beyond the limit.
    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) && w_we |-> (r_m < {1'b0, r_n}))
        else $error("multiple struck beyond the limit");

    // Candidate loading stays below the limit.
    a_init_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (r_addr < r_n)) else $error("load beyond the limit");

    // A listed prime is at least two, and an out-of-range result carries none.
    a_prime_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_has |-> (r_out_value >= VAL_W'(2)) && !r_out_status)
        else $error("bad prime in result");

    // Commands are taken only by an idle sequencer.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE) && i_cmd_valid)
        else $error("command taken while busy");

endmodule
